>>> rtl/doy2jd_pkg.sv
// ----------------------------------------------------------------------------
// doy2jd_pkg - shared types and constants
// Field widths, month tables and stage load controls for the day-of-year to
// Julian date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package doy2jd_pkg;

  localparam int YEAR_W  = 12;
  localparam int DOY_W   = 41;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 26;
  localparam int JDN_W   = 22;
  localparam int JFRAC_W = 32;

  localparam int NUM_MONTHS = 12;
  localparam int TAB_W      = 9;

  // Integer part of 1721013.5; the half day lives in the fraction path.
  localparam logic [JDN_W-1:0] JD_OFFSET = 22'd1721013;

  // Largest day of month before saturation.
  localparam logic [DOM_W-1:0] DOM_MAX = 6'd63;

  // Sixty seconds in Q20, an exclusive bound on the seconds output.
  localparam logic [SEC_W-1:0] SEC_LIMIT = 26'd62914560;

  typedef logic [TAB_W-1:0] day_tab_t [NUM_MONTHS];

  // Days elapsed before the first of each month.
  localparam day_tab_t START_COMMON = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam day_tab_t START_LEAP = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // floor(275 * month / 9) for months 1 to 12.
  localparam day_tab_t DAYS_275 = '{
    9'd30, 9'd61, 9'd91, 9'd122, 9'd152, 9'd183,
    9'd213, 9'd244, 9'd275, 9'd305, 9'd336, 9'd366
  };

  // Per-stage load strobes from the pipeline control.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ld_t;

endpackage

`default_nettype wire

>>> rtl/doy2jd_cal.sv
// ----------------------------------------------------------------------------
// doy2jd_cal - calendar and Julian day path
// Three stages: month decode, day of month and year term, Julian day sum.
// ----------------------------------------------------------------------------
`default_nettype none

module doy2jd_cal #(
  parameter int FRAC_BITS = 32
) (
  input  wire                                 clk,
  input  doy2jd_pkg::stage_ld_t               ld,
  input  wire  [doy2jd_pkg::YEAR_W-1:0]       full_year,
  input  wire  [doy2jd_pkg::DOY_W-1:0]        day_of_year_q32,
  output logic [doy2jd_pkg::MONTH_W-1:0]      month,
  output logic [doy2jd_pkg::DOM_W-1:0]        day_of_month,
  output logic [doy2jd_pkg::JDN_W-1:0]        julian_day_number,
  output logic [doy2jd_pkg::JFRAC_W-1:0]      julian_fraction_q32
);

  localparam int WHOLE_W = doy2jd_pkg::DOY_W - FRAC_BITS;
  localparam int FSH     = doy2jd_pkg::JFRAC_W - FRAC_BITS;
  localparam int JW      = doy2jd_pkg::JDN_W;
  localparam int MW      = doy2jd_pkg::MONTH_W;

  // ---- stage 1 ----
  logic [WHOLE_W-1:0]                   whole;
  logic [FRAC_BITS-1:0]                 frac;
  logic [doy2jd_pkg::JFRAC_W-1:0]       f32;
  logic                                 leap;
  logic [MW-1:0]                        past_cnt;

  logic [doy2jd_pkg::YEAR_W-1:0]        year1_r;
  logic [WHOLE_W-1:0]                   whole1_r;
  logic                                 leap1_r;
  logic [MW-1:0]                        mon1_r;
  logic                                 carry1_r;
  logic [doy2jd_pkg::JFRAC_W-1:0]       jfrac1_r;

  assign whole = day_of_year_q32[doy2jd_pkg::DOY_W-1:FRAC_BITS];
  assign frac  = day_of_year_q32[FRAC_BITS-1:0];
  assign f32   = doy2jd_pkg::JFRAC_W'(frac) << FSH;
  assign leap  = (full_year[1:0] == 2'b00);

  // Count month starts strictly below the whole day.
  always_comb begin
    past_cnt = '0;
    for (int m = 1; m < doy2jd_pkg::NUM_MONTHS; m++) begin
      if (leap) begin
        if (whole > WHOLE_W'(doy2jd_pkg::START_LEAP[m])) past_cnt = past_cnt + 1'b1;
      end else begin
        if (whole > WHOLE_W'(doy2jd_pkg::START_COMMON[m])) past_cnt = past_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      year1_r  <= full_year;
      whole1_r <= whole;
      leap1_r  <= leap;
      mon1_r   <= past_cnt + 1'b1;
      // Adding a half day flips the top bit and carries into the day number.
      carry1_r <= f32[doy2jd_pkg::JFRAC_W-1];
      jfrac1_r <= {~f32[doy2jd_pkg::JFRAC_W-1], f32[doy2jd_pkg::JFRAC_W-2:0]};
    end
  end

  // ---- stage 2 ----
  logic [MW-1:0]                        idx;
  logic [doy2jd_pkg::TAB_W-1:0]         acc;
  logic [WHOLE_W-1:0]                   dayw;
  logic [doy2jd_pkg::YEAR_W:0]          ysum;
  logic [20:0]                          y367;
  logic [15:0]                          y7;

  logic [MW-1:0]                        mon2_r;
  logic [doy2jd_pkg::DOM_W-1:0]         dom2_r;
  logic [WHOLE_W-1:0]                   dayw2_r;
  logic [JW-1:0]                        ypart2_r;
  logic [doy2jd_pkg::TAB_W-1:0]         d275_2_r;
  logic                                 carry2_r;
  logic [doy2jd_pkg::JFRAC_W-1:0]       jfrac2_r;

  assign idx  = mon1_r - 1'b1;
  assign acc  = leap1_r ? doy2jd_pkg::START_LEAP[idx] : doy2jd_pkg::START_COMMON[idx];
  assign dayw = whole1_r - WHOLE_W'(acc);
  assign ysum = (doy2jd_pkg::YEAR_W+1)'(year1_r) + (doy2jd_pkg::YEAR_W+1)'(mon1_r >= 4'd3);
  assign y367 = 21'(year1_r) * 21'd367;
  assign y7   = 16'(ysum) * 16'd7;

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      mon2_r   <= mon1_r;
      dom2_r   <= (dayw > WHOLE_W'(doy2jd_pkg::DOM_MAX)) ? doy2jd_pkg::DOM_MAX
                                                          : dayw[doy2jd_pkg::DOM_W-1:0];
      dayw2_r  <= dayw;
      ypart2_r <= JW'(y367) - JW'(y7[15:2]);
      d275_2_r <= doy2jd_pkg::DAYS_275[idx];
      carry2_r <= carry1_r;
      jfrac2_r <= jfrac1_r;
    end
  end

  // ---- stage 3 ----
  logic [MW-1:0]                        mon3_r;
  logic [doy2jd_pkg::DOM_W-1:0]         dom3_r;
  logic [JW-1:0]                        jdn3_r;
  logic [doy2jd_pkg::JFRAC_W-1:0]       jfrac3_r;

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      mon3_r   <= mon2_r;
      dom3_r   <= dom2_r;
      jdn3_r   <= ypart2_r + JW'(d275_2_r) + JW'(dayw2_r) + doy2jd_pkg::JD_OFFSET
                  + JW'(carry2_r);
      jfrac3_r <= jfrac2_r;
    end
  end

  assign month               = mon3_r;
  assign day_of_month        = dom3_r;
  assign julian_day_number   = jdn3_r;
  assign julian_fraction_q32 = jfrac3_r;

endmodule

`default_nettype wire

>>> rtl/doy2jd_tod.sv
// ----------------------------------------------------------------------------
// doy2jd_tod - time of day path
// Splits the day fraction into hour, minute and Q20 seconds, one constant
// multiply per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module doy2jd_tod #(
  parameter int FRAC_BITS = 32
) (
  input  wire                              clk,
  input  doy2jd_pkg::stage_ld_t            ld,
  input  wire  [FRAC_BITS-1:0]             frac,
  output logic [doy2jd_pkg::HOUR_W-1:0]    hour,
  output logic [doy2jd_pkg::MIN_W-1:0]     minute_of_hour,
  output logic [doy2jd_pkg::SEC_W-1:0]     second_q20
);

  localparam int T1_W = FRAC_BITS + 5;
  localparam int T2_W = FRAC_BITS + 6;

  logic [T1_W-1:0]                  t1_r;
  logic [doy2jd_pkg::HOUR_W-1:0]    hr2_r;
  logic [T2_W-1:0]                  t2_r;
  logic [doy2jd_pkg::HOUR_W-1:0]    hr3_r;
  logic [doy2jd_pkg::MIN_W-1:0]     mn3_r;
  logic [T2_W-1:0]                  s3_r;

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      t1_r <= T1_W'(frac) * T1_W'(24);
    end
    if (ld.ld2) begin
      hr2_r <= t1_r[T1_W-1:FRAC_BITS];
      t2_r  <= T2_W'(t1_r[FRAC_BITS-1:0]) * T2_W'(60);
    end
    if (ld.ld3) begin
      hr3_r <= hr2_r;
      mn3_r <= t2_r[T2_W-1:FRAC_BITS];
      s3_r  <= T2_W'(t2_r[FRAC_BITS-1:0]) * T2_W'(60);
    end
  end

  // Realign seconds from the input scale to Q20.
  generate
    if (FRAC_BITS >= 20) begin : g_sec_down
      assign second_q20 = s3_r[T2_W-1 -: doy2jd_pkg::SEC_W];
    end else begin : g_sec_up
      assign second_q20 = {s3_r, {(20 - FRAC_BITS){1'b0}}};
    end
  endgenerate

  assign hour           = hr3_r;
  assign minute_of_hour = mn3_r;

endmodule

`default_nettype wire

>>> rtl/day_of_year_to_julian_date.sv
// ----------------------------------------------------------------------------
// day_of_year_to_julian_date - day of year to calendar and Julian date
// Converts a year and a fixed-point day of year into month, day of month,
// hour, minute, Q20 seconds and a Julian date split into day number and
// Q32 fraction.
// ----------------------------------------------------------------------------
//
//   channel  ports                              dir  handshake
//   -------  ---------------------------------  ---  -----------------------
//   in       in_full_year, in_day_of_year_q32   in   in_valid / in_stall
//   out      out_month .. out_julian_fraction   out  out_valid / out_stall
//
// One beat enters per cycle while in_stall is low. Depth is set by the
// time-of-day chain, one constant multiply per stage, with the calendar
// path cut to match.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// A stall on the output holds the last stage and backs up stage by stage;
// bubbles are squeezed out, so in_stall rises only when all stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module day_of_year_to_julian_date #(
  parameter int FRAC_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input beat
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [doy2jd_pkg::YEAR_W-1:0]        in_full_year,
  input  wire  [doy2jd_pkg::DOY_W-1:0]         in_day_of_year_q32,
  // result beat
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [doy2jd_pkg::MONTH_W-1:0]       out_month,
  output logic [doy2jd_pkg::DOM_W-1:0]         out_day_of_month,
  output logic [doy2jd_pkg::HOUR_W-1:0]        out_hour,
  output logic [doy2jd_pkg::MIN_W-1:0]         out_minute_of_hour,
  output logic [doy2jd_pkg::SEC_W-1:0]         out_second_q20,
  output logic [doy2jd_pkg::JDN_W-1:0]         out_julian_day_number,
  output logic [doy2jd_pkg::JFRAC_W-1:0]       out_julian_fraction_q32
);

  // Stage valid bits travel alongside the datapath registers in the
  // calendar and time-of-day units.
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;
  doy2jd_pkg::stage_ld_t ld;

  // A stage may take new data when it is empty or its contents move on.
  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  // Load data only when a valid beat arrives; hold otherwise.
  assign ld.ld1 = rdy1 && in_valid;
  assign ld.ld2 = rdy2 && v1_r;
  assign ld.ld3 = rdy3 && v2_r;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = v3_r;

  // Month, day of month and Julian date.
  doy2jd_cal #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cal (
    .clk                 (clk),
    .ld                  (ld),
    .full_year           (in_full_year),
    .day_of_year_q32     (in_day_of_year_q32),
    .month               (out_month),
    .day_of_month        (out_day_of_month),
    .julian_day_number   (out_julian_day_number),
    .julian_fraction_q32 (out_julian_fraction_q32)
  );

  // Hour, minute and seconds from the fraction of the day.
  doy2jd_tod #(
    .FRAC_BITS (FRAC_BITS)
  ) u_tod (
    .clk            (clk),
    .ld             (ld),
    .frac           (in_day_of_year_q32[FRAC_BITS-1:0]),
    .hour           (out_hour),
    .minute_of_hour (out_minute_of_hour),
    .second_q20     (out_second_q20)
  );

`ifndef SYNTH
  // An accepted beat always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted beat lost at stage 1");

  // A blocked middle stage keeps its beat.
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy2 |=> v2_r)
    else $error("stage 2 dropped a stalled beat");

  // Input stalls only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r)
    else $error("input stalled with a free stage");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month >= 4'd1 && out_month <= 4'd12)
    else $error("month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour <= 5'd23 && out_minute_of_hour <= 6'd59
                  && out_second_q20 < doy2jd_pkg::SEC_LIMIT)
    else $error("time of day out of range");
`endif

endmodule

`default_nettype wire

>>> tb/day_of_year_to_julian_date_tb.sv
// ----------------------------------------------------------------------------
// day_of_year_to_julian_date_tb - self-checking bench for the date converter
// Drives year and fixed-point day-of-year beats through the converter, first
// from a short directed table, then from random beats. Both sides idle and
// stall at random, and one long output hold fills the pipeline. Each result
// beat is compared field by field to its typed row or the in-bench model.
// ----------------------------------------------------------------------------

module day_of_year_to_julian_date_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part size, receiver hold-off and run limits.
  localparam int RANDOM_BEATS   = 1700;
  localparam int HOLD_AT_BEAT   = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_WAIT       = 17;
  localparam int DRAIN_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DIRECTED_ROWS  = 24;

  // Fixed-point layout of the day of year: 9 whole-day bits over 32 fraction bits.
  localparam int Q_BITS = 32;

  // Common-year month lengths; February grows to 29 in leap years.
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Whole days that sit on or next to month and year boundaries, and the field top.
  localparam int EDGE_DAYS [14] = '{0, 1, 31, 32, 58, 59, 60, 61, 334, 335, 365, 366, 367, 511};

  typedef struct packed {
    logic [doy2jd_pkg::MONTH_W-1:0] month;
    logic [doy2jd_pkg::DOM_W-1:0]   day_of_month;
    logic [doy2jd_pkg::HOUR_W-1:0]  hour;
    logic [doy2jd_pkg::MIN_W-1:0]   minute_of_hour;
    logic [doy2jd_pkg::SEC_W-1:0]   second_q20;
    logic [doy2jd_pkg::JDN_W-1:0]   julian_day_number;
    logic [doy2jd_pkg::JFRAC_W-1:0] julian_fraction_q32;
  } calendar_t;

  // One row of the directed table; typed rows carry a hand-read result.
  typedef struct packed {
    logic [doy2jd_pkg::YEAR_W-1:0] year;
    logic [doy2jd_pkg::DOY_W-1:0]  doy;
    logic                          typed;
    calendar_t                     want;
  } date_row_t;

  // What the sender offered, in offer order, for the monitor to resolve.
  typedef struct packed {
    logic      typed;
    calendar_t want;
  } date_offer_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid           = 1'b0;
  logic                             in_stall;
  logic [doy2jd_pkg::YEAR_W-1:0]    in_full_year       = '0;
  logic [doy2jd_pkg::DOY_W-1:0]     in_day_of_year_q32 = '0;

  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [doy2jd_pkg::MONTH_W-1:0]   out_month;
  logic [doy2jd_pkg::DOM_W-1:0]     out_day_of_month;
  logic [doy2jd_pkg::HOUR_W-1:0]    out_hour;
  logic [doy2jd_pkg::MIN_W-1:0]     out_minute_of_hour;
  logic [doy2jd_pkg::SEC_W-1:0]     out_second_q20;
  logic [doy2jd_pkg::JDN_W-1:0]     out_julian_day_number;
  logic [doy2jd_pkg::JFRAC_W-1:0]   out_julian_fraction_q32;

  date_offer_t offered_dates [$];
  calendar_t   pending_calendars [$];

  date_offer_t accepted_offer;
  calendar_t   due_calendar;

  int mismatch_count   = 0;
  int results_checked  = 0;
  int beats_sent       = 0;
  int cycle_count      = 0;

  // Directed table. Typed rows: J2000 noon, day zero of 1900, February 1 of 2001.
  // All others are resolved by the calendar model.
  localparam date_row_t DATE_TABLE [DIRECTED_ROWS] = '{
    // January 1, 2000 at noon lands exactly on a whole Julian day.
    '{12'd2000, 41'h001_8000_0000, 1'b1,
      '{4'd1, 6'd1, 5'd12, 6'd0, 26'd0, 22'd2451545, 32'h0000_0000}},
    // Day zero: month 1, day 0, midnight.
    '{12'd1900, 41'h000_0000_0000, 1'b1,
      '{4'd1, 6'd0, 5'd0, 6'd0, 26'd0, 22'd2415018, 32'h8000_0000}},
    '{12'd2001, 41'h020_0000_0000, 1'b1,
      '{4'd2, 6'd1, 5'd0, 6'd0, 26'd0, 22'd2451941, 32'h8000_0000}},
    // Field extremes.
    '{12'd4095, 41'h1FF_FFFF_FFFF, 1'b0, '0},
    '{12'd0,    41'h000_0000_0000, 1'b0, '0},
    '{12'd4095, 41'h000_0000_0000, 1'b0, '0},
    '{12'h800,  41'h100_0000_0000, 1'b0, '0},
    '{12'd2099, 41'h16D_FFFF_FFFF, 1'b0, '0},
    // Leap and common February ends.
    '{12'd2000, 41'h03C_0000_0000, 1'b0, '0},
    '{12'd2000, 41'h03D_0000_0000, 1'b0, '0},
    '{12'd2001, 41'h03B_0000_0000, 1'b0, '0},
    '{12'd2001, 41'h03C_0000_0000, 1'b0, '0},
    // Past December, then an oversized day that saturates the day of month.
    '{12'd2000, 41'h16E_0000_0000, 1'b0, '0},
    '{12'd2000, 41'h16F_0000_0000, 1'b0, '0},
    '{12'd2001, 41'h16F_0000_0000, 1'b0, '0},
    '{12'd2024, 41'h1FF_0000_0000, 1'b0, '0},
    // Either side of the half-day carry into the day number.
    '{12'd2024, 41'h064_7FFF_FFFF, 1'b0, '0},
    '{12'd2024, 41'h064_8000_0000, 1'b0, '0},
    '{12'd1999, 41'h0C8_0000_0001, 1'b0, '0},
    // Alternating fraction bits.
    '{12'd1900, 41'h001_AAAA_AAAA, 1'b0, '0},
    '{12'd2099, 41'h0FA_5555_5555, 1'b0, '0},
    // November 30 and December 1.
    '{12'd2023, 41'h14E_0000_0000, 1'b0, '0},
    '{12'd2023, 41'h14F_0000_0000, 1'b0, '0},
    '{12'd1904, 41'h03C_C000_0000, 1'b0, '0}
  };

  day_of_year_to_julian_date u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_full_year            (in_full_year),
    .in_day_of_year_q32      (in_day_of_year_q32),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_month               (out_month),
    .out_day_of_month        (out_day_of_month),
    .out_hour                (out_hour),
    .out_minute_of_hour      (out_minute_of_hour),
    .out_second_q20          (out_second_q20),
    .out_julian_day_number   (out_julian_day_number),
    .out_julian_fraction_q32 (out_julian_fraction_q32)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Calendar model: month walk over the length table, truncating h/m/s split
  // of the day fraction, Vallado day number with the half-day carry.
  function automatic calendar_t predict_calendar(logic [doy2jd_pkg::YEAR_W-1:0] year,
                                                 logic [doy2jd_pkg::DOY_W-1:0] doy);
    logic [63:0] yr;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] acc;
    logic [63:0] mon;
    logic [63:0] len;
    logic [63:0] dom;
    logic [63:0] prod;
    logic [63:0] hr;
    logic [63:0] mn;
    logic [63:0] sec_q;
    logic [63:0] sec20;
    logic [63:0] march_on;
    logic [63:0] day_num;
    logic        leap;
    logic        walking;
    calendar_t   res;
    yr      = {52'd0, year};
    whole   = {55'd0, doy[doy2jd_pkg::DOY_W-1:Q_BITS]};
    frac    = {32'd0, doy[Q_BITS-1:0]};
    leap    = (year[1:0] == 2'b00);
    acc     = 64'd0;
    mon     = 64'd1;
    walking = 1'b1;
    // Step month by month while the day lies past the current month's end.
    while (walking && mon < 64'd12) begin
      len = 64'(MONTH_DAYS[mon[3:0] - 4'd1]);
      if (mon == 64'd2 && leap) begin
        len = 64'd29;
      end
      if (whole > acc + len) begin
        acc = acc + len;
        mon = mon + 64'd1;
      end else begin
        walking = 1'b0;
      end
    end
    dom = whole - acc;

    prod  = frac * 64'd24;
    hr    = prod >> Q_BITS;
    prod  = {32'd0, prod[31:0]} * 64'd60;
    mn    = prod >> Q_BITS;
    sec_q = {32'd0, prod[31:0]} * 64'd60;
    sec20 = sec_q >> (Q_BITS - 20);

    march_on = (mon >= 64'd3) ? 64'd1 : 64'd0;
    day_num  = 64'd367 * yr - (64'd7 * (yr + march_on)) / 64'd4
             + (64'd275 * mon) / 64'd9 + dom + {42'd0, doy2jd_pkg::JD_OFFSET};

    // Add the half day; a fraction at or past noon carries into the day number.
    if (doy[Q_BITS-1]) begin
      res.julian_fraction_q32 = {1'b0, doy[Q_BITS-2:0]};
      day_num = day_num + 64'd1;
    end else begin
      res.julian_fraction_q32 = {1'b1, doy[Q_BITS-2:0]};
    end

    res.month             = mon[doy2jd_pkg::MONTH_W-1:0];
    res.day_of_month      = (dom > 64'd63) ? doy2jd_pkg::DOM_MAX
                                           : dom[doy2jd_pkg::DOM_W-1:0];
    res.hour              = hr[doy2jd_pkg::HOUR_W-1:0];
    res.minute_of_hour    = mn[doy2jd_pkg::MIN_W-1:0];
    res.second_q20        = sec20[doy2jd_pkg::SEC_W-1:0];
    res.julian_day_number = day_num[doy2jd_pkg::JDN_W-1:0];
    return res;
  endfunction

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Offer one beat after an idle gap; hold it until the converter takes it.
  task automatic send_date(logic [doy2jd_pkg::YEAR_W-1:0] year,
                           logic [doy2jd_pkg::DOY_W-1:0] doy,
                           date_offer_t offer, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_full_year       <= year;
    in_day_of_year_q32 <= doy;
    in_valid           <= 1'b1;
    offered_dates.push_back(offer);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Monitor. Sample pre-edge values: log each accepted input beat as an
  // expectation, then retire each accepted result beat against the oldest one.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      accepted_offer = offered_dates.pop_front();
      if (accepted_offer.typed) begin
        pending_calendars.push_back(accepted_offer.want);
      end else begin
        pending_calendars.push_back(predict_calendar(in_full_year, in_day_of_year_q32));
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_calendars.size() == 0) begin
        $error("result beat with no conversion pending");
        mismatch_count++;
      end else begin
        due_calendar = pending_calendars.pop_front();
        check_field("month", 64'(due_calendar.month), 64'(out_month));
        check_field("day_of_month", 64'(due_calendar.day_of_month), 64'(out_day_of_month));
        check_field("hour", 64'(due_calendar.hour), 64'(out_hour));
        check_field("minute_of_hour", 64'(due_calendar.minute_of_hour),
                    64'(out_minute_of_hour));
        check_field("second_q20", 64'(due_calendar.second_q20), 64'(out_second_q20));
        check_field("julian_day_number", 64'(due_calendar.julian_day_number),
                    64'(out_julian_day_number));
        check_field("julian_fraction_q32", 64'(due_calendar.julian_fraction_q32),
                    64'(out_julian_fraction_q32));
        results_checked++;
      end
    end
  end

  // Watchdog: drop the run if it overstays the cycle budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver. Stall a random number of cycles before each result beat, with
  // quiet stretches of no stall, and one long hold so the pipeline backs up
  // into in_stall while the sender keeps offering.
  initial begin : receiver
    int beats_taken;
    int hold;
    beats_taken = 0;
    @(posedge clk);
    forever begin
      if (beats_taken == HOLD_AT_BEAT) begin
        hold = HOLD_CYCLES;
      end else begin
        hold = draw_wait(((beats_taken / 50) % 3) == 1);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
      beats_taken++;
    end
  end

  // Sender and run control.
  initial begin : sender
    date_offer_t                   offer;
    logic [doy2jd_pkg::YEAR_W-1:0] year_v;
    logic [8:0]                    whole_v;
    logic [31:0]                   frac_v;
    int                            mode;

    // Hold reset at the start, then release.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer.typed = DATE_TABLE[r].typed;
      offer.want  = DATE_TABLE[r].want;
      send_date(DATE_TABLE[r].year, DATE_TABLE[r].doy, offer, draw_wait(1'b0));
    end

    // Random beats: mostly in-range years and days, with boundary days, odd
    // fractions and some full-width noise.
    offer.typed = 1'b0;
    offer.want  = '0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      mode    = $urandom_range(0, 15);
      year_v  = doy2jd_pkg::YEAR_W'($urandom_range(1900, 2099));
      whole_v = 9'($urandom_range(0, 366));
      if (mode == 0) begin
        year_v  = doy2jd_pkg::YEAR_W'($urandom_range(0, 4095));
        whole_v = 9'($urandom_range(0, 511));
      end else if (mode == 1) begin
        year_v  = doy2jd_pkg::YEAR_W'($urandom_range(0, 4095));
      end else if (mode <= 4) begin
        whole_v = 9'(EDGE_DAYS[4'($urandom_range(0, 13))]);
      end
      case ($urandom_range(0, 7))
        0:       frac_v = 32'h0000_0000;
        1:       frac_v = 32'hFFFF_FFFF;
        2:       frac_v = 32'h8000_0000;
        3:       frac_v = 32'h7FFF_FFFF;
        default: frac_v = $urandom;
      endcase
      send_date(year_v, {whole_v, frac_v}, offer, draw_wait(((i / 64) % 3) == 0));
    end
    in_valid <= 1'b0;

    // Drain: wait for every expectation to retire, then idle a few cycles to
    // catch any stray result beat.
    while (offered_dates.size() != 0 || pending_calendars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_calendars.size() != 0) begin
      $error("%0d conversions never produced a result", pending_calendars.size());
      mismatch_count++;
    end

    $display("covered %0d conversions (%0d directed, %0d random), %0d results checked",
             beats_sent, DIRECTED_ROWS, RANDOM_BEATS, results_checked);
    $display("full-width years and days, boundary days, half-day carry, %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
